>>> design/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants of the heightmap bilinear sampler
// Field widths, mode codes, stream packing and the state types of the
// front and back sequencers.
// ----------------------------------------------------------------------------
package hbs_pkg;

  // Field widths of the input and result items.
  localparam int CIDX_W  = 10;
  localparam int HGT_W   = 8;
  localparam int POS_W   = 24;
  localparam int INV_W   = 16;
  localparam int FRAC_W  = 8;
  localparam int HQ8_W   = 16;

  // Stream packing: tdata holds cell_index, height_sample, pos_x, pos_z.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  // Reset value of the reciprocal cell size (1.0 in Q8.8).
  localparam logic [INV_W-1:0] INV_RESET = 16'd256;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Item modes carried on tuser.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Front sequencer: accept, scale both axes, hand over a command.
  typedef enum logic [1:0] {
    F_IDLE,
    F_MULX,
    F_MULZ,
    F_PUSH
  } front_state_t;

  // Back sequencer: store write, or four corner reads and the blend.
  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_Q0,
    B_Q1,
    B_Q2,
    B_Q3,
    B_Q4,
    B_OUT
  } back_state_t;

endpackage

>>> design/heightmap_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler: bilinear height lookup on a square grid
// The block stores a GRID_SIZE x GRID_SIZE grid of 8-bit heights in a
// single-port RAM, which is not cleared at reset: every corner cell a query
// touches must have been loaded first. A load item (tuser 0) writes one
// height and returns a zero result; a query item (tuser 1) scales (x, -z)
// by the Q8.8 reciprocal cell size, clamps each axis onto the grid, sets
// out_of_grid when it clamped, and returns the bilinear blend of the four
// corner heights in unsigned Q8.8. Every item gives exactly one result, in
// order. The back end takes a query through four corner reads on the single
// RAM port, one accumulate and one output, and a load through a store write
// and an output; the front end takes a query through intake, x and then z
// through one shared multiplier and hand-over to the queue, and a load
// through intake and hand-over. A two-entry command queue lets the two ends
// overlap. The register inv_cell_size resets to 1.0 and is written on the
// cfg channel, by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler #(
  parameter int GRID_SIZE = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: cell_index[9:0], height_sample[17:10], pos_x[41:18],
  // pos_z[65:42], zero fill [71:66]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hbs_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: mode[0]
  input  logic                             in_tuser,
  // out_tdata: height_q8[15:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hbs_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: out_of_grid[0]
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hbs_pkg::INV_W-1:0]        cfg_data
);

  import hbs_pkg::*;

  localparam int AW    = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int CMD_W = 3 + 3 * 8 + 4 * AW;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [CMD_W-1:0] q_wdata;
  logic [CMD_W-1:0] q_rdata;

  // The register write is always taken; the user must write only while idle.
  assign cfg_ready = 1'b1;

  hbs_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_mode          (in_tuser),
    .in_cell_index    (in_tdata[9:0]),
    .in_height_sample (in_tdata[17:10]),
    .in_pos_x         (in_tdata[41:18]),
    .in_pos_z         (in_tdata[65:42]),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .q_push           (q_push),
    .q_wdata          (q_wdata),
    .q_full           (q_full)
  );

  hbs_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  hbs_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_height_q8 (out_tdata),
    .out_of_grid   (out_tuser)
  );

endmodule

>>> design/hbs_ram.sv
// ----------------------------------------------------------------------------
// hbs_ram: generic single-port RAM
// One address per cycle, written or read; the read data is registered.
// ----------------------------------------------------------------------------
module hbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read of the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/hbs_queue.sv
// ----------------------------------------------------------------------------
// hbs_queue: short command queue
// A small register FIFO that lets the front and back sequencers stall
// independently of each other.
// ----------------------------------------------------------------------------
module hbs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> design/hbs_front.sv
// ----------------------------------------------------------------------------
// hbs_front: item intake and position scaling
// Accepts input items, holds the reciprocal cell size, scales a query
// position into grid units, splits and clamps each axis and hands a
// command to the queue: a load's write, or a query's four corner addresses.
// ----------------------------------------------------------------------------
module hbs_front #(
  parameter int GRID_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          in_mode,
  input  logic [hbs_pkg::CIDX_W-1:0]    in_cell_index,
  input  logic [hbs_pkg::HGT_W-1:0]     in_height_sample,
  input  logic [hbs_pkg::POS_W-1:0]     in_pos_x,
  input  logic [hbs_pkg::POS_W-1:0]     in_pos_z,
  input  logic                          cfg_valid,
  input  logic [hbs_pkg::INV_W-1:0]     cfg_data,
  output logic                          q_push,
  output logic [3+3*8+4*$clog2(GRID_SIZE*GRID_SIZE)-1:0] q_wdata,
  input  logic                          q_full
);

  import hbs_pkg::*;

  localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int XW         = $clog2(GRID_SIZE);
  localparam int PROD_W     = POS_W + 1 + INV_W + 1;
  localparam logic signed [PROD_W-1:0] LAST_G = PROD_W'((GRID_SIZE - 1) * 65536);

  typedef struct packed {
    logic              is_load;
    logic              wen;
    logic              oog;
    logic [7:0]        fx;
    logic [7:0]        fz;
    logic [7:0]        wdata;
    logic [AW-1:0]     a0;
    logic [AW-1:0]     a1;
    logic [AW-1:0]     a2;
    logic [AW-1:0]     a3;
  } cmd_t;

  front_state_t state_r, state_nxt;

  logic                     mode_r;
  logic [CIDX_W-1:0]        cidx_r;
  logic [HGT_W-1:0]         hs_r;
  logic [POS_W-1:0]         px_r;
  logic [POS_W-1:0]         pz_r;
  logic [INV_W-1:0]         inv_r;
  logic signed [PROD_W-1:0] gx_r;
  logic signed [PROD_W-1:0] gz_r;

  logic                     in_fire;
  logic signed [POS_W:0]    mul_a;
  logic signed [INV_W:0]    mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [XW+FRAC_W:0]       split_x;
  logic [XW+FRAC_W:0]       split_z;
  logic [XW-1:0]            col0, col1, row0, row1;
  cmd_t                     cmd;

  // Clamp one axis onto the grid: {out-of-grid, index, fraction}.
  function automatic logic [XW+FRAC_W:0] split_axis(input logic signed [PROD_W-1:0] g);
    logic [XW+FRAC_W:0] r;
    if (g[PROD_W-1]) begin
      r = {1'b1, {XW{1'b0}}, {FRAC_W{1'b0}}};
    end else if (g > LAST_G) begin
      r = {1'b1, XW'(GRID_SIZE - 1), {FRAC_W{1'b0}}};
    end else begin
      r = {1'b0, g[16+XW-1:16], g[15:8]};
    end
    return r;
  endfunction

  assign in_fire = in_tvalid && in_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_mode == MODE_QUERY) ? F_MULX : F_PUSH;
        end
      end
      F_MULX:  state_nxt = F_MULZ;
      F_MULZ:  state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE:  in_tready = 1'b1;
      F_PUSH:  q_push    = !q_full;
      default: begin
        in_tready = 1'b0;
        q_push    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      inv_r   <= INV_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        inv_r <= cfg_data;
      end
    end
  end

  // One shared multiplier scales x, then the negated z.
  assign mul_a = (state_r == F_MULX) ? $signed({px_r[POS_W-1], px_r})
                                     : -$signed({pz_r[POS_W-1], pz_r});
  assign mul_b = $signed({1'b0, inv_r});
  assign prod  = mul_a * mul_b;

  // Item capture and scaled coordinates.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_mode;
      cidx_r <= in_cell_index;
      hs_r   <= in_height_sample;
      px_r   <= in_pos_x;
      pz_r   <= in_pos_z;
    end
    if (state_r == F_MULX) begin
      gx_r <= prod;
    end
    if (state_r == F_MULZ) begin
      gz_r <= prod;
    end
  end

  // Split both axes and form the corner addresses.
  assign split_x = split_axis(gx_r);
  assign split_z = split_axis(gz_r);
  assign col0    = split_x[XW+FRAC_W-1:FRAC_W];
  assign row0    = split_z[XW+FRAC_W-1:FRAC_W];
  assign col1    = (col0 == XW'(GRID_SIZE - 1)) ? col0 : col0 + 1'b1;
  assign row1    = (row0 == XW'(GRID_SIZE - 1)) ? row0 : row0 + 1'b1;

  always_comb begin
    cmd = '0;
    if (mode_r == MODE_LOAD) begin
      cmd.is_load = 1'b1;
      cmd.wen     = (32'(cidx_r) < CELL_COUNT);
      cmd.wdata   = hs_r;
      cmd.a0      = AW'(cidx_r);
    end else begin
      cmd.oog = split_x[XW+FRAC_W] | split_z[XW+FRAC_W];
      cmd.fx  = split_x[FRAC_W-1:0];
      cmd.fz  = split_z[FRAC_W-1:0];
      cmd.a0  = AW'(32'(row0) * GRID_SIZE + 32'(col0));
      cmd.a1  = AW'(32'(row0) * GRID_SIZE + 32'(col1));
      cmd.a2  = AW'(32'(row1) * GRID_SIZE + 32'(col0));
      cmd.a3  = AW'(32'(row1) * GRID_SIZE + 32'(col1));
    end
  end

  assign q_wdata = cmd;

endmodule

>>> design/hbs_back.sv
// ----------------------------------------------------------------------------
// hbs_back: height store access and bilinear blend
// Takes commands from the queue, writes loads into the height store,
// reads the four corners of a query one per cycle, accumulates the
// weighted sum and holds the result in the output register.
// ----------------------------------------------------------------------------
module hbs_back #(
  parameter int GRID_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [3+3*8+4*$clog2(GRID_SIZE*GRID_SIZE)-1:0] q_rdata,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hbs_pkg::HQ8_W-1:0]     out_height_q8,
  output logic                          out_of_grid
);

  import hbs_pkg::*;

  localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int WGT_W      = 2 * FRAC_W + 1;
  localparam int ACC_W      = HGT_W + 2 * FRAC_W;

  typedef struct packed {
    logic              is_load;
    logic              wen;
    logic              oog;
    logic [7:0]        fx;
    logic [7:0]        fz;
    logic [7:0]        wdata;
    logic [AW-1:0]     a0;
    logic [AW-1:0]     a1;
    logic [AW-1:0]     a2;
    logic [AW-1:0]     a3;
  } cmd_t;

  back_state_t state_r, state_nxt;

  cmd_t               head;
  cmd_t               cmd_r;
  logic               out_free;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [HGT_W-1:0]   mem_rdata;
  logic [FRAC_W:0]    fac_x, fac_z;
  logic [WGT_W-1:0]   wgt_r;
  logic [ACC_W-1:0]   acc_r;
  logic               acc_en;
  logic               wgt_en;
  logic               out_valid_r;
  logic [HQ8_W-1:0]   out_height_r;
  logic               out_oog_r;

  assign head     = cmd_t'(q_rdata);
  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = head.is_load ? B_LOAD : B_Q0;
        end
      end
      B_LOAD:  state_nxt = B_OUT;
      B_Q0:    state_nxt = B_Q1;
      B_Q1:    state_nxt = B_Q2;
      B_Q2:    state_nxt = B_Q3;
      B_Q3:    state_nxt = B_Q4;
      B_Q4:    state_nxt = B_OUT;
      B_OUT: begin
        if (out_free) begin
          if (!q_empty) begin
            state_nxt = head.is_load ? B_LOAD : B_Q0;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Sequencer outputs: store port, corner weights, accumulate enables.
  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    mem_addr = cmd_r.a0;
    fac_x    = 9'd256 - {1'b0, cmd_r.fx};
    fac_z    = 9'd256 - {1'b0, cmd_r.fz};
    wgt_en   = 1'b0;
    acc_en   = 1'b0;
    case (state_r)
      B_IDLE: q_pop = !q_empty;
      B_LOAD: mem_we = cmd_r.wen;
      B_Q0: begin
        wgt_en = 1'b1;
      end
      B_Q1: begin
        mem_addr = cmd_r.a1;
        fac_x    = {1'b0, cmd_r.fx};
        wgt_en   = 1'b1;
        acc_en   = 1'b1;
      end
      B_Q2: begin
        mem_addr = cmd_r.a2;
        fac_z    = {1'b0, cmd_r.fz};
        wgt_en   = 1'b1;
        acc_en   = 1'b1;
      end
      B_Q3: begin
        mem_addr = cmd_r.a3;
        fac_x    = {1'b0, cmd_r.fx};
        fac_z    = {1'b0, cmd_r.fz};
        wgt_en   = 1'b1;
        acc_en   = 1'b1;
      end
      B_Q4:  acc_en = 1'b1;
      B_OUT: q_pop  = out_free && !q_empty;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command, weight and accumulator registers. The weight of a corner is
  // registered in the cycle its read is issued, so both meet in the next cycle.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= head;
      acc_r <= '0;
    end else if (acc_en) begin
      acc_r <= acc_r + ACC_W'(mem_rdata * wgt_r);
    end
    if (wgt_en) begin
      wgt_r <= WGT_W'(fac_x * fac_z);
    end
    if (state_r == B_OUT && out_free) begin
      out_height_r <= acc_r[ACC_W-1:ACC_W-HQ8_W];
      out_oog_r    <= cmd_r.oog;
    end
  end

  hbs_ram #(
    .WIDTH (HGT_W),
    .DEPTH (CELL_COUNT)
  ) u_height_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (cmd_r.wdata),
    .rdata (mem_rdata)
  );

  assign out_tvalid    = out_valid_r;
  assign out_height_q8 = out_height_r;
  assign out_of_grid   = out_oog_r;

  // A query always walks all four corners before its result is formed.
  a_corner_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_Q0) |=> (state_r == B_Q1) ##1 (state_r == B_Q2)
      ##1 (state_r == B_Q3) ##1 (state_r == B_Q4) ##1 (state_r == B_OUT))
    else $error("query left the corner read sequence");

  // A load transfers a zero height without the out-of-grid flag.
  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && out_free && cmd_r.is_load)
      |=> (out_valid_r && out_height_r == '0 && !out_oog_r))
    else $error("load result is not zero");

  // Commands leave the queue only when the back end is free for them.
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_empty && (state_r == B_IDLE || state_r == B_OUT)))
    else $error("command taken while busy or from an empty queue");

endmodule
